FILE: rtl/vector3_alu_macros.svh
// Assertion macros shared by the vector ALU modules.
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/v3alu_pkg.sv
// Types, constants and arithmetic helpers of the vector ALU.
`timescale 1ns / 1ps
package v3alu_pkg;

  localparam int CW  = 32;          // component width
  localparam int FB  = 16;          // fraction bits
  localparam int PW  = 2 * CW;      // product width
  localparam int SW  = PW + 2;      // sum of three products
  localparam int RW  = CW + 2;      // square root remainder
  localparam int QB  = FB + 1;      // normalize quotient bits
  localparam int NW  = CW + FB + 1; // normalize dividend
  localparam int QD  = 2;           // queue depth, power of two
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DOT   = 3'd2,
    OP_CROSS = 3'd3,
    OP_NORM  = 3'd4,
    OP_NONE  = 3'd7
  } op_t;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    op_t   op;
    comp_t ax;
    comp_t ay;
    comp_t az;
    comp_t bx;
    comp_t by;
    comp_t bz;
  } cmd_t;

  typedef struct packed {
    comp_t rx;
    comp_t ry;
    comp_t rz;
    comp_t scalar;
    logic  overflow;
    logic  zero_length;
  } res_t;

  typedef struct packed {
    logic  ovf;
    comp_t val;
  } sat_t;

  function automatic sat_t saturate(input logic signed [SW-1:0] v);
    sat_t r;
    if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) begin
      r.ovf = 1'b0;
      r.val = v[CW-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // round half up, then drop the fraction bits
  function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v + HALF;
    return t >>> FB;
  endfunction

  function automatic logic [CW-1:0] magn(input comp_t a);
    logic [CW-1:0] u;
    u = a;
    return a[CW-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

FILE: rtl/v3alu_req_if.sv
// Request channel of the vector ALU.
`timescale 1ns / 1ps
interface v3alu_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  v3alu_pkg::comp_t    ax;
  v3alu_pkg::comp_t    ay;
  v3alu_pkg::comp_t    az;
  v3alu_pkg::comp_t    bx;
  v3alu_pkg::comp_t    by;
  v3alu_pkg::comp_t    bz;

  modport source (output valid, mode, ax, ay, az, bx, by, bz, input ready);
  modport sink   (input valid, mode, ax, ay, az, bx, by, bz, output ready);
endinterface

FILE: rtl/v3alu_rsp_if.sv
// Response channel of the vector ALU.
`timescale 1ns / 1ps
interface v3alu_rsp_if;
  logic             valid;
  logic             ready;
  v3alu_pkg::comp_t rx;
  v3alu_pkg::comp_t ry;
  v3alu_pkg::comp_t rz;
  v3alu_pkg::comp_t scalar;
  logic             overflow;
  logic             zero_length;

  modport source (output valid, rx, ry, rz, scalar, overflow, zero_length, input ready);
  modport sink   (input valid, rx, ry, rz, scalar, overflow, zero_length, output ready);
endinterface

FILE: rtl/v3alu_front.sv
// Front end: takes requests, decodes the mode and pushes commands into the queue.
`timescale 1ns / 1ps
module v3alu_front (
  v3alu_req_if.sink          req,
  input  logic               full,
  output logic               push,
  output v3alu_pkg::cmd_t    push_data
);

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    push_data.ax = req.ax;
    push_data.ay = req.ay;
    push_data.az = req.az;
    push_data.bx = req.bx;
    push_data.by = req.by;
    push_data.bz = req.bz;
    unique case (req.mode)
      v3alu_pkg::OP_ADD:   push_data.op = v3alu_pkg::OP_ADD;
      v3alu_pkg::OP_SUB:   push_data.op = v3alu_pkg::OP_SUB;
      v3alu_pkg::OP_DOT:   push_data.op = v3alu_pkg::OP_DOT;
      v3alu_pkg::OP_CROSS: push_data.op = v3alu_pkg::OP_CROSS;
      v3alu_pkg::OP_NORM:  push_data.op = v3alu_pkg::OP_NORM;
      default:             push_data.op = v3alu_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: rtl/v3alu_fifo.sv
// Command queue between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps
`include "vector3_alu_macros.svh"
module v3alu_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  v3alu_pkg::cmd_t    push_data,
  output logic               full,
  input  logic               pop,
  output v3alu_pkg::cmd_t    pop_data,
  output logic               not_empty
);

  v3alu_pkg::cmd_t                  mem [v3alu_pkg::QD];
  logic [v3alu_pkg::QAW-1:0]        wr_ptr;
  logic [v3alu_pkg::QAW-1:0]        rd_ptr;
  logic [v3alu_pkg::QCW-1:0]        count;
  logic [v3alu_pkg::QCW-1:0]        count_next;

  assign full      = (count == v3alu_pkg::QCW'(v3alu_pkg::QD));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  assign count_next = count + v3alu_pkg::QCW'(push) - v3alu_pkg::QCW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  `ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `ASSERT_IMP(a_no_pop_empty, pop, not_empty, "pop from empty queue")
  `ASSERT_NEXT(a_push_fills, push && !pop, count != '0, "queue empty after push")

endmodule

FILE: rtl/v3alu_back.sv
// Arithmetic pipeline: products, sums, square root, normalize division, result register.
`timescale 1ns / 1ps
`include "vector3_alu_macros.svh"
module v3alu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  v3alu_pkg::cmd_t    cmd,
  output logic               cmd_pop,
  v3alu_rsp_if.source        rsp
);

  localparam int CW = v3alu_pkg::CW;
  localparam int FB = v3alu_pkg::FB;
  localparam int PW = v3alu_pkg::PW;
  localparam int SW = v3alu_pkg::SW;
  localparam int RW = v3alu_pkg::RW;
  localparam int QB = v3alu_pkg::QB;
  localparam int NW = v3alu_pkg::NW;
  localparam int NP = CW + QB + 2;

  typedef struct packed {
    logic                  valid;
    v3alu_pkg::op_t        op;
    v3alu_pkg::res_t       res;
    logic [PW-1:0]         srest;
    logic [CW-1:0]         root;
    logic [RW-1:0]         srem;
    logic [2:0][CW-1:0]    mag;
    logic [2:0]            neg;
    logic [2:0][CW-1:0]    drem;
    logic [2:0][QB-1:0]    nlow;
    logic [2:0][QB-1:0]    q;
  } pipe_t;

  function automatic pipe_t sq_step(input pipe_t p);
    pipe_t         r;
    logic [RW-1:0] remx;
    logic [RW-1:0] trial;
    r       = p;
    remx    = {p.srem[RW-3:0], p.srest[PW-1 -: 2]};
    trial   = {p.root, 2'b01};
    r.srest = {p.srest[PW-3:0], 2'b00};
    if (remx >= trial) begin
      r.srem = remx - trial;
      r.root = {p.root[CW-2:0], 1'b1};
    end else begin
      r.srem = remx;
      r.root = {p.root[CW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic pipe_t div_init(input pipe_t p);
    pipe_t         r;
    logic [NW-1:0] n;
    r = p;
    for (int j = 0; j < 3; j++) begin
      n         = {1'b0, p.mag[j], {FB{1'b0}}} + NW'(p.root >> 1);
      r.drem[j] = n[NW-1:QB];
      r.nlow[j] = n[QB-1:0];
      r.q[j]    = '0;
    end
    return r;
  endfunction

  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       r;
    logic [CW:0] remx;
    r = p;
    for (int j = 0; j < 3; j++) begin
      remx      = {p.drem[j], p.nlow[j][QB-1]};
      r.nlow[j] = {p.nlow[j][QB-2:0], 1'b0};
      if (remx >= {1'b0, p.root}) begin
        r.drem[j] = CW'(remx - {1'b0, p.root});
        r.q[j]    = {p.q[j][QB-2:0], 1'b1};
      end else begin
        r.drem[j] = remx[CW-1:0];
        r.q[j]    = {p.q[j][QB-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic v3alu_pkg::res_t finish(input pipe_t p);
    v3alu_pkg::res_t     r;
    v3alu_pkg::sat_t     t [3];
    logic signed [SW-1:0] v;
    r = p.res;
    for (int j = 0; j < 3; j++) begin
      v = signed'(SW'(p.q[j]));
      if (p.neg[j]) v = -v;
      t[j] = v3alu_pkg::saturate(v);
    end
    if (p.op == v3alu_pkg::OP_NORM && !p.res.zero_length) begin
      r.rx       = t[0].val;
      r.ry       = t[1].val;
      r.rz       = t[2].val;
      r.overflow = t[0].ovf | t[1].ovf | t[2].ovf;
    end
    return r;
  endfunction

  logic                  ce;
  v3alu_pkg::comp_t      opa [6];
  v3alu_pkg::comp_t      opb [6];
  logic signed [PW-1:0]  prod_next [6];
  logic                  s0_valid;
  v3alu_pkg::cmd_t       s0_cmd;
  logic signed [PW-1:0]  s0_prod [6];
  pipe_t                 pipe_head;
  pipe_t                 pipe [NP];
  pipe_t                 pipe_next [NP];
  logic                  out_valid;
  v3alu_pkg::res_t       out_res;

  assign ce      = !out_valid || rsp.ready;
  assign cmd_pop = ce && cmd_valid;

  // operand routing for the six multipliers
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    unique case (cmd.op)
      v3alu_pkg::OP_DOT: begin
        opa[0] = cmd.ax; opb[0] = cmd.bx;
        opa[1] = cmd.ay; opb[1] = cmd.by;
        opa[2] = cmd.az; opb[2] = cmd.bz;
      end
      v3alu_pkg::OP_CROSS: begin
        opa[0] = cmd.ay; opb[0] = cmd.bz;
        opa[1] = cmd.az; opb[1] = cmd.by;
        opa[2] = cmd.az; opb[2] = cmd.bx;
        opa[3] = cmd.ax; opb[3] = cmd.bz;
        opa[4] = cmd.ax; opb[4] = cmd.by;
        opa[5] = cmd.ay; opb[5] = cmd.bx;
      end
      v3alu_pkg::OP_NORM: begin
        opa[0] = cmd.ax; opb[0] = cmd.ax;
        opa[1] = cmd.ay; opb[1] = cmd.ay;
        opa[2] = cmd.az; opb[2] = cmd.az;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) prod_next[k] = opa[k] * opb[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (ce) begin
      s0_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_cmd <= cmd;
      for (int k = 0; k < 6; k++) s0_prod[k] <= prod_next[k];
    end
  end

  // sums, rounding and saturation; square root setup
  always_comb begin
    logic signed [SW-1:0] sum3;
    logic signed [SW-1:0] ex;
    logic signed [SW-1:0] ey;
    logic signed [SW-1:0] ez;
    v3alu_pkg::sat_t      tx;
    v3alu_pkg::sat_t      ty;
    v3alu_pkg::sat_t      tz;
    pipe_t                p;
    p       = '0;
    p.valid = s0_valid;
    p.op    = s0_cmd.op;
    sum3    = SW'(s0_prod[0]) + SW'(s0_prod[1]) + SW'(s0_prod[2]);
    ex      = '0;
    ey      = '0;
    ez      = '0;
    unique case (s0_cmd.op)
      v3alu_pkg::OP_ADD: begin
        ex = SW'(s0_cmd.ax) + SW'(s0_cmd.bx);
        ey = SW'(s0_cmd.ay) + SW'(s0_cmd.by);
        ez = SW'(s0_cmd.az) + SW'(s0_cmd.bz);
      end
      v3alu_pkg::OP_SUB: begin
        ex = SW'(s0_cmd.ax) - SW'(s0_cmd.bx);
        ey = SW'(s0_cmd.ay) - SW'(s0_cmd.by);
        ez = SW'(s0_cmd.az) - SW'(s0_cmd.bz);
      end
      v3alu_pkg::OP_CROSS: begin
        ex = v3alu_pkg::rnd(SW'(s0_prod[0]) - SW'(s0_prod[1]));
        ey = v3alu_pkg::rnd(SW'(s0_prod[2]) - SW'(s0_prod[3]));
        ez = v3alu_pkg::rnd(SW'(s0_prod[4]) - SW'(s0_prod[5]));
      end
      default: begin
      end
    endcase
    tx = v3alu_pkg::saturate(ex);
    ty = v3alu_pkg::saturate(ey);
    tz = v3alu_pkg::saturate(ez);
    if (s0_cmd.op == v3alu_pkg::OP_DOT) begin
      tx = v3alu_pkg::saturate(v3alu_pkg::rnd(sum3));
      p.res.scalar   = tx.val;
      p.res.overflow = tx.ovf;
    end else begin
      p.res.rx       = tx.val;
      p.res.ry       = ty.val;
      p.res.rz       = tz.val;
      p.res.overflow = tx.ovf | ty.ovf | tz.ovf;
    end
    if (s0_cmd.op == v3alu_pkg::OP_NORM) begin
      p.srest             = sum3[PW-1:0];
      p.res.zero_length   = (sum3[PW-1:0] == '0);
      p.mag[0]            = v3alu_pkg::magn(s0_cmd.ax);
      p.mag[1]            = v3alu_pkg::magn(s0_cmd.ay);
      p.mag[2]            = v3alu_pkg::magn(s0_cmd.az);
      p.neg               = {s0_cmd.az[CW-1], s0_cmd.ay[CW-1], s0_cmd.ax[CW-1]};
    end
    pipe_head = p;
  end

  always_comb begin
    pipe_next[0] = pipe_head;
    for (int i = 0; i < CW; i++) pipe_next[i+1] = sq_step(pipe[i]);
    pipe_next[CW+1] = div_init(pipe[CW]);
    for (int k = 0; k < QB; k++) pipe_next[CW+2+k] = div_step(pipe[CW+1+k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NP; i++) pipe[i].valid <= 1'b0;
    end else if (ce) begin
      pipe <= pipe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= pipe[NP-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) out_res <= finish(pipe[NP-1]);
  end

  assign rsp.valid       = out_valid;
  assign rsp.rx          = out_res.rx;
  assign rsp.ry          = out_res.ry;
  assign rsp.rz          = out_res.rz;
  assign rsp.scalar      = out_res.scalar;
  assign rsp.overflow    = out_res.overflow;
  assign rsp.zero_length = out_res.zero_length;

  `ASSERT_IMP(a_zl_clean, out_valid && out_res.zero_length, out_res.rx == '0 && out_res.ry == '0 && out_res.rz == '0 && out_res.scalar == '0 && !out_res.overflow, "zero-length result not clean")
  `ASSERT_IMP(a_scalar_alone, out_valid && out_res.scalar != '0, out_res.rx == '0 && out_res.ry == '0 && out_res.rz == '0, "scalar with nonzero vector")
  `ASSERT_NEXT(a_pipe_moves, ce && pipe[0].valid, pipe[1].valid, "request lost in pipeline")

endmodule

FILE: rtl/vector3_alu.sv
// Top level of the three-component Q16.16 vector ALU.
`timescale 1ns / 1ps
// Takes one request per cycle while the queue is not full and returns one
// result per request, in order. An accepted request passes through the
// queue, the product register, the pipeline registers and the result
// register. The depth is set by the normalize path: a 32-stage digit-by-digit
// square root (one result bit per stage) followed by a 17-stage restoring
// divider for the three components in parallel. Every mode flows through
// the same pipeline, so add, subtract, dot and cross take the same latency.
// When the result is not taken the whole pipeline holds and the queue
// absorbs up to two more requests. Modes 5 to 7 return all zeros.
module vector3_alu (
  input  logic        clk,
  input  logic        rst,
  v3alu_req_if.sink   req,
  v3alu_rsp_if.source rsp
);

  logic            push;
  logic            full;
  logic            pop;
  logic            not_empty;
  v3alu_pkg::cmd_t push_data;
  v3alu_pkg::cmd_t pop_data;

  v3alu_front u_front (
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  v3alu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  v3alu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (not_empty),
    .cmd       (pop_data),
    .cmd_pop   (pop),
    .rsp       (rsp)
  );

endmodule

FILE: verif/vector3_alu_test.sv
// Self-checking testbench of the three-component vector ALU.
`timescale 1ns / 1ps
module vector3_alu_test;
  import v3alu_pkg::*;

  logic clk;
  logic rst;
  v3alu_req_if req ();
  v3alu_rsp_if rsp ();

  vector3_alu uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  cmd_t pending_reqs[$];
  res_t expected_results[$];
  int   errors;
  int   sent;
  int   send_idle_pct;
  int   recv_idle_pct;

  localparam int DRAIN_AT = 400;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic comp_t clamp(input logic signed [79:0] v, inout bit ovf);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = 80'sd2147483647;
    lo = -80'sd2147483648;
    if (v > hi) begin
      ovf = 1'b1;
      return comp_t'(hi);
    end
    if (v < lo) begin
      ovf = 1'b1;
      return comp_t'(lo);
    end
    return comp_t'(v);
  endfunction

  function automatic res_t predict_result(input cmd_t c);
    logic signed [79:0] a[3];
    logic signed [79:0] b[3];
    logic signed [79:0] t;
    logic [79:0] m;
    logic [79:0] q;
    logic [65:0] s;
    logic [65:0] cw;
    logic [32:0] len;
    logic [32:0] cand;
    comp_t r[3];
    res_t o;
    bit ovf;
    int j;
    int k;
    a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
    b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
    r[0] = '0; r[1] = '0; r[2] = '0;
    o = '0;
    ovf = 1'b0;
    case (c.op)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++)
          r[i] = clamp(c.op == OP_ADD ? a[i] + b[i] : a[i] - b[i], ovf);
      end
      OP_DOT: begin
        t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        o.scalar = clamp((t + 80'sd32768) >>> FB, ovf);
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          t = a[j] * b[k] - a[k] * b[j];
          r[i] = clamp((t + 80'sd32768) >>> FB, ovf);
        end
      end
      OP_NORM: begin
        s = '0;
        for (int i = 0; i < 3; i++) begin
          m = a[i] < 0 ? -a[i] : a[i];
          s = s + 66'(m * m);
        end
        if (s == 0) begin
          o.zero_length = 1'b1;
        end else begin
          len = '0;
          for (int bb = 32; bb >= 0; bb--) begin
            cand = len | (33'd1 << bb);
            cw = cand;
            if (cw * cw <= s) len = cand;
          end
          for (int i = 0; i < 3; i++) begin
            m = a[i] < 0 ? -a[i] : a[i];
            q = ((m << FB) + (len >> 1)) / len;
            t = a[i] < 0 ? -$signed(q) : $signed(q);
            r[i] = clamp(t, ovf);
          end
        end
      end
      default: ;
    endcase
    o.rx = r[0];
    o.ry = r[1];
    o.rz = r[2];
    o.overflow = ovf;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    cmd_t c;
    bit fire;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_result(cmd_t'({req.mode, req.ax, req.ay, req.az,
                                                          req.bx, req.by, req.bz})));
        sent++;
      end
      if (!req.valid || req.ready) begin
        fire = pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (sent + (req.valid && req.ready ? 0 : 0) == DRAIN_AT && expected_results.size() != 0)
          fire = 1'b0;
        if (req.valid && req.ready && sent == DRAIN_AT) fire = 1'b0;
        if (fire) begin
          c = pending_reqs.pop_front();
          req.mode <= c.op;
          req.ax <= c.ax; req.ay <= c.ay; req.az <= c.az;
          req.bx <= c.bx; req.by <= c.by; req.bz <= c.bz;
        end
        req.valid <= fire;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result rx=%h ry=%h rz=%h", $realtime, rsp.rx, rsp.ry, rsp.rz);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (rsp.rx !== e.rx) begin
            $display("%0t: rx expected %h actual %h", $realtime, e.rx, rsp.rx);
            errors++;
          end
          if (rsp.ry !== e.ry) begin
            $display("%0t: ry expected %h actual %h", $realtime, e.ry, rsp.ry);
            errors++;
          end
          if (rsp.rz !== e.rz) begin
            $display("%0t: rz expected %h actual %h", $realtime, e.rz, rsp.rz);
            errors++;
          end
          if (rsp.scalar !== e.scalar) begin
            $display("%0t: scalar expected %h actual %h", $realtime, e.scalar, rsp.scalar);
            errors++;
          end
          if (rsp.overflow !== e.overflow) begin
            $display("%0t: overflow expected %b actual %b", $realtime, e.overflow, rsp.overflow);
            errors++;
          end
          if (rsp.zero_length !== e.zero_length) begin
            $display("%0t: zero_length expected %b actual %b", $realtime, e.zero_length,
                     rsp.zero_length);
            errors++;
          end
        end
      end
      rsp.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  function automatic comp_t rand_comp();
    case ($urandom_range(5))
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      2: return comp_t'($signed($urandom_range(65535)) - 32768);
      3: return '0;
      default: return comp_t'($signed($urandom_range(32'h1ffffff)) - 32'sh1000000);
    endcase
  endfunction

  task automatic add_req(input logic [2:0] op, input comp_t ax, ay, az, bx, by, bz);
    cmd_t c;
    c.op = op_t'(op);
    c.ax = ax; c.ay = ay; c.az = az;
    c.bx = bx; c.by = by; c.bz = bz;
    pending_reqs.push_back(c);
  endtask

  initial begin
    comp_t mx;
    comp_t mn;
    logic [2:0] op;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    errors = 0;
    sent = 0;
    send_idle_pct = 7;
    recv_idle_pct = 62;
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = '0;
    req.ax = '0; req.ay = '0; req.az = '0;
    req.bx = '0; req.by = '0; req.bz = '0;
    rsp.ready = 1'b0;

    add_req(OP_ADD, mx, mn, 32'sh10000, mx, mn, 32'sh10000);
    add_req(OP_ADD, mx, mn, -1, mn, mx, 1);
    add_req(OP_SUB, mx, mn, 0, mn, mx, 0);
    add_req(OP_SUB, 5, -5, mn, 3, 7, mn);
    add_req(OP_DOT, mx, mx, mx, mx, mx, mx);
    add_req(OP_DOT, mn, mn, mn, mx, mx, mx);
    add_req(OP_DOT, 32'sh8000, 1, 0, 1, 1, 0);
    add_req(OP_DOT, -32'sh8000, 0, 0, 1, 0, 0);
    add_req(OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0);
    add_req(OP_CROSS, mx, mn, mx, mn, mx, mn);
    add_req(OP_CROSS, mn, mn, mn, mn, mx, 0);
    add_req(OP_NORM, 0, 0, 0, 5, 6, 7);
    add_req(OP_NORM, mn, mn, mn, 0, 0, 0);
    add_req(OP_NORM, 1, 0, 0, 0, 0, 0);
    add_req(OP_NORM, -1, 0, 0, 0, 0, 0);
    add_req(OP_NORM, 3, 4, 0, 0, 0, 0);
    add_req(OP_NORM, mx, 1, -1, 0, 0, 0);
    add_req(3'd5, mx, mx, mx, mx, mx, mx);
    add_req(3'd6, 1, 2, 3, 4, 5, 6);
    add_req(OP_NONE, mn, mn, mn, mn, mn, mn);
    for (int n = 0; n < 1150; n++) begin
      op = $urandom_range(15) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if (op == OP_NORM && $urandom_range(9) == 0)
        add_req(op, 0, 0, 0, rand_comp(), rand_comp(), rand_comp());
      else
        add_req(op, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp());
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (sent >= 400);
    send_idle_pct = 62;
    recv_idle_pct = 7;
    wait (sent >= 800);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_reqs.size() == 0 && !req.valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/v3alu_pkg.sv
rtl/v3alu_req_if.sv
rtl/v3alu_rsp_if.sv
rtl/v3alu_front.sv
rtl/v3alu_fifo.sv
rtl/v3alu_back.sv
rtl/vector3_alu.sv
verif/vector3_alu_test.sv
